// ===== hw/rtl/ehpd_pkg.sv =====
// ehpd_pkg: shared types and codes for the exception-header pointer decoder
// used by the channel interfaces and the top level; depends on nothing
package ehpd_pkg;

	typedef logic [63:0] word_t;
	typedef logic [7:0]  byte_t;
	typedef logic [3:0]  count_t;
	typedef logic [1:0]  status_t;

	// command of one input item
	localparam logic CMD_BEGIN = 1'b0;
	localparam logic CMD_BYTE  = 1'b1;

	// whole-byte encodings with a meaning of their own
	localparam byte_t ENC_OMIT    = 8'hff;
	localparam byte_t ENC_ALIGNED = 8'h50;

	// value formats, low nibble of the encoding
	localparam logic [3:0] FMT_ABSPTR = 4'h0;
	localparam logic [3:0] FMT_ULEB   = 4'h1;
	localparam logic [3:0] FMT_U2     = 4'h2;
	localparam logic [3:0] FMT_U4     = 4'h3;
	localparam logic [3:0] FMT_U8     = 4'h4;
	localparam logic [3:0] FMT_SLEB   = 4'h9;
	localparam logic [3:0] FMT_S2     = 4'ha;
	localparam logic [3:0] FMT_S4     = 4'hb;
	localparam logic [3:0] FMT_S8     = 4'hc;
	localparam logic [3:0] FMT_U1     = 4'hd;
	localparam logic [3:0] FMT_S1     = 4'he;

	// relative modes, encoding bits 6:4
	localparam logic [2:0] MODE_PCREL   = 3'd1;
	localparam logic [2:0] MODE_DATAREL = 3'd3;
	localparam logic [2:0] MODE_FUNCREL = 3'd4;

	// result status
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_LEB_LONG  = 2'd1;
	localparam status_t ST_ALIGN_OVF = 2'd2;

endpackage

// ===== hw/rtl/ehpd_in_if.sv =====
// ehpd_in_if: input item channel of the pointer decoder, valid/ready handshake
// depends on ehpd_pkg
interface ehpd_in_if import ehpd_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  cmd;
	byte_t encoding;
	word_t start_addr;
	word_t data_base;
	word_t func_base;
	byte_t data_byte;

	modport source (
		output valid, cmd, encoding, start_addr, data_base, func_base, data_byte,
		input  ready
	);
	modport sink (
		input  valid, cmd, encoding, start_addr, data_base, func_base, data_byte,
		output ready
	);
endinterface

// ===== hw/rtl/ehpd_out_if.sv =====
// ehpd_out_if: result item channel of the pointer decoder, valid/ready handshake
// depends on ehpd_pkg
interface ehpd_out_if import ehpd_pkg::*; ();
	logic    valid;
	logic    ready;
	word_t   value;
	count_t  bytes_used;
	status_t status;

	modport source (
		output valid, value, bytes_used, status,
		input  ready
	);
	modport sink (
		input  valid, value, bytes_used, status,
		output ready
	);
endinterface

// ===== hw/rtl/eh_pointer_encoding_decoder.sv =====
// eh_pointer_encoding_decoder: decodes one exception-header pointer from a byte stream
// the item that completes a result passes the input register, then the result register
// throughput: one item per cycle while the result register does not stall
// the only stall is a full result register that the sink does not take
// reset (arst_n low, asynchronous) empties both registers and leaves the decoder idle
// depends on ehpd_pkg, ehpd_in_if, ehpd_out_if
module eh_pointer_encoding_decoder import ehpd_pkg::*; #(
	parameter int POINTER_BYTES = 8,
	parameter int MAX_LEB_BYTES = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	ehpd_in_if.sink    stream,
	ehpd_out_if.source result
);

	// pointer length, overlong limit, highest start address that can still be aligned
	localparam count_t PtrLen     = 4'(POINTER_BYTES);
	localparam count_t MaxLeb     = 4'(MAX_LEB_BYTES);
	localparam word_t  AlignLimit = ~64'(POINTER_BYTES - 1);

	// weight of byte idx of an address, that is 256**idx mod POINTER_BYTES
	function automatic int byte_weight(input int idx);
		int w;
		w = 1;
		for (int i = 0; i < idx; i++) begin
			w = (w * 256) % POINTER_BYTES;
		end
		return w;
	endfunction

	localparam int W1 = byte_weight(1);

	// ---------------------------------------------------------------
	// input register
	// ---------------------------------------------------------------
	logic  valid_s1;
	logic  cmd_s1;
	byte_t enc_s1;
	word_t start_s1;
	word_t dbase_s1;
	word_t fbase_s1;
	byte_t byte_s1;

	logic res_valid_q;
	logic slot_free;
	logic advance;

	// the input register moves on whenever the result register is empty or being taken
	assign slot_free    = !res_valid_q || result.ready;
	assign advance      = valid_s1 && slot_free;
	assign stream.ready = !valid_s1 || slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			cmd_s1   <= stream.cmd;
			enc_s1   <= stream.encoding;
			start_s1 <= stream.start_addr;
			dbase_s1 <= stream.data_base;
			fbase_s1 <= stream.func_base;
			byte_s1  <= stream.data_byte;
		end
	end

	// ---------------------------------------------------------------
	// decoder state
	// ---------------------------------------------------------------
	logic   busy_q;      // a value is in progress
	logic   leb_q;       // value is LEB128
	logic   sleb_q;      // value is signed LEB128
	logic   sext_q;      // fixed field narrower than 64 bits to sign-extend
	count_t count_q;     // stream bytes taken so far, padding included
	logic [2:0] pad_left_q;
	count_t len_q;       // fixed field length in bytes
	count_t target_q;    // padding plus field length
	word_t  acc_q;
	word_t  base_q;      // base picked by the relative mode, zero if none

	logic   busy_d, leb_d, sleb_d, sext_d;
	count_t count_d, len_d, target_d;
	logic [2:0] pad_left_d;
	word_t  acc_d, base_d;

	logic    emit_c;
	word_t   value_c;
	count_t  used_c;
	status_t status_c;

	// begin-side decode
	logic [3:0]  fmt;
	logic [2:0]  mode;
	count_t      len_c;
	logic        fmt_signed_c;
	logic        fmt_leb_c;
	word_t       base_sel;

	// alignment padding: start address folded down, then reduced mod POINTER_BYTES
	logic [13:0] fold1;
	logic [9:0]  fold2;
	logic [8:0]  fold3;
	logic [9:0]  rem;
	logic [2:0]  pad_c;

	// byte-side datapath
	count_t      count_inc;
	logic [6:0]  leb_sh;
	logic [6:0]  leb_sh_next;
	word_t       leb_acc;
	word_t       shift_acc;
	word_t       fixed_val;
	logic [6:0]  field_bits;

	always_comb begin
		fmt  = enc_s1[3:0];
		mode = enc_s1[6:4];

		unique case (fmt)
			FMT_ABSPTR:     len_c = PtrLen;
			FMT_U2, FMT_S2: len_c = 4'd2;
			FMT_U4, FMT_S4: len_c = 4'd4;
			FMT_U8, FMT_S8: len_c = 4'd8;
			FMT_U1, FMT_S1: len_c = 4'd1;
			default:        len_c = 4'd0;
		endcase
		fmt_signed_c = (fmt == FMT_S2) || (fmt == FMT_S4) || (fmt == FMT_S8)
			|| (fmt == FMT_S1);
		fmt_leb_c = (fmt == FMT_ULEB) || (fmt == FMT_SLEB);

		unique case (mode)
			MODE_PCREL:   base_sel = start_s1;
			MODE_DATAREL: base_sel = dbase_s1;
			MODE_FUNCREL: base_sel = fbase_s1;
			default:      base_sel = '0;
		endcase

		fold1 = '0;
		for (int i = 0; i < 8; i++) begin
			fold1 = fold1 + 14'(start_s1[8*i +: 8]) * 14'(byte_weight(i));
		end
		fold2 = 10'(fold1[7:0]) + 10'(fold1[13:8]) * 10'(W1);
		fold3 = 9'(fold2[7:0]) + 9'(fold2[9:8]) * 9'(W1);
		rem   = {1'b0, fold3};
		for (int k = 6; k >= 0; k--) begin
			if (rem >= 10'(POINTER_BYTES << k)) begin
				rem = rem - 10'(POINTER_BYTES << k);
			end
		end
		pad_c = (rem == '0) ? 3'd0 : 3'(PtrLen - rem[3:0]);

		// LEB128: seven payload bits per byte, bits at 64 and above fall off
		count_inc   = count_q + 4'd1;
		leb_sh      = 7'({count_q, 3'b000} - {3'b000, count_q});
		leb_sh_next = leb_sh + 7'd7;
		leb_acc     = acc_q | ({57'd0, byte_s1[6:0]} << leb_sh);
		if (sleb_q && !byte_s1[7] && byte_s1[6]) begin
			leb_acc = leb_acc | (~64'd0 << leb_sh_next);
		end

		// fixed field: bytes enter from the top, the field ends up in the high bytes
		shift_acc  = {byte_s1, acc_q[63:8]};
		field_bits = {len_q[3:0], 3'b000};
		fixed_val  = shift_acc >> (7'd64 - field_bits);
		if (sext_q && shift_acc[63]) begin
			fixed_val = fixed_val | (~64'd0 << field_bits);
		end

		busy_d     = busy_q;
		leb_d      = leb_q;
		sleb_d     = sleb_q;
		sext_d     = sext_q;
		count_d    = count_q;
		len_d      = len_q;
		target_d   = target_q;
		pad_left_d = pad_left_q;
		acc_d      = acc_q;
		base_d     = base_q;
		emit_c     = 1'b0;
		value_c    = '0;
		used_c     = '0;
		status_c   = ST_OK;

		if (cmd_s1 == CMD_BEGIN) begin
			// a begin always restarts, abandoning any value in progress
			busy_d     = 1'b0;
			leb_d      = fmt_leb_c;
			sleb_d     = (fmt == FMT_SLEB);
			sext_d     = fmt_signed_c && (len_c < 4'd8);
			count_d    = '0;
			len_d      = len_c;
			target_d   = len_c;
			pad_left_d = '0;
			acc_d      = '0;
			base_d     = base_sel;
			if (enc_s1 == ENC_OMIT) begin
				emit_c = 1'b1;
			end else if (enc_s1 == ENC_ALIGNED) begin
				leb_d  = 1'b0;
				sext_d = 1'b0;
				if (start_s1 > AlignLimit) begin
					emit_c   = 1'b1;
					status_c = ST_ALIGN_OVF;
				end else begin
					busy_d     = 1'b1;
					pad_left_d = pad_c;
					len_d      = PtrLen;
					target_d   = 4'({1'b0, pad_c} + PtrLen);
				end
			end else if (fmt_leb_c || (len_c != '0)) begin
				busy_d = 1'b1;
			end else begin
				// undefined format: no bytes, just the base
				emit_c  = 1'b1;
				value_c = base_sel;
			end
		end else if (busy_q) begin
			count_d = count_inc;
			if (leb_q) begin
				acc_d = leb_acc;
				if (!byte_s1[7]) begin
					busy_d  = 1'b0;
					emit_c  = 1'b1;
					value_c = leb_acc + base_q;
					used_c  = count_inc;
				end else if (count_inc >= MaxLeb) begin
					busy_d   = 1'b0;
					emit_c   = 1'b1;
					used_c   = count_inc;
					status_c = ST_LEB_LONG;
				end
			end else if (pad_left_q != '0) begin
				pad_left_d = pad_left_q - 3'd1;
			end else begin
				acc_d = shift_acc;
				if (count_inc >= target_q) begin
					busy_d  = 1'b0;
					emit_c  = 1'b1;
					value_c = fixed_val + base_q;
					used_c  = count_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			count_q    <= '0;
			pad_left_q <= '0;
		end else if (advance) begin
			busy_q     <= busy_d;
			count_q    <= count_d;
			pad_left_q <= pad_left_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			leb_q    <= leb_d;
			sleb_q   <= sleb_d;
			sext_q   <= sext_d;
			len_q    <= len_d;
			target_q <= target_d;
			acc_q    <= acc_d;
			base_q   <= base_d;
		end
	end

	// ---------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------
	word_t   res_value_q;
	count_t  res_used_q;
	status_t res_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= emit_c;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit_c) begin
			res_value_q  <= value_c;
			res_used_q   <= used_c;
			res_status_q <= status_c;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.value      = res_value_q;
	assign result.bytes_used = res_used_q;
	assign result.status     = res_status_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	a_align_ovf_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_status_q == ST_ALIGN_OVF) |-> (res_used_q == '0)
			&& (res_value_q == '0))
		else $error("alignment overflow result carries bytes or a value");

	a_leb_long_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_status_q == ST_LEB_LONG) |-> (res_used_q == MaxLeb))
		else $error("overlong result with wrong byte count");

	a_pad_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pad_left_q != '0) |-> busy_q && !leb_q)
		else $error("padding left while no aligned value is in progress");

	a_fixed_below_target: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !leb_q |-> (count_q < target_q))
		else $error("fixed field ran past its length");

	a_leb_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && leb_q |-> (count_q < MaxLeb))
		else $error("LEB128 value ran past the byte limit");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!stream.ready |-> valid_s1 && res_valid_q && !result.ready)
		else $error("input stalled without a blocked result");

endmodule
